// ===== hdl/slt_pkg.sv =====
// shared types and codes for the sorted list table
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned COUNT_OUT_W = 7;

  // request codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                    cmp_en;
    logic                    upd_ins;
    logic                    upd_del;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/slt_req_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface slt_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic signed [slt_pkg::KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface slt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [1:0]                          status;
  logic [slt_pkg::COUNT_OUT_W-1:0]     entry_count;

  modport source (output valid, output found, output status, output entry_count,
                  input ready);
  modport sink (input valid, input found, input status, input entry_count,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/slt_cell.sv =====
// one cell of the sorted key chain: holds a key, compares, shifts
`timescale 1ns / 1ps
`default_nettype none
module slt_cell (
  input  wire logic                             clk,
  input  wire slt_pkg::cell_cmd_t               cmd,
  input  wire logic                             occupied,
  input  wire logic                             at_end,
  input  wire logic signed [slt_pkg::KEY_W-1:0] left_key,
  input  wire logic                             left_ge,
  input  wire logic signed [slt_pkg::KEY_W-1:0] right_key,
  output logic signed [slt_pkg::KEY_W-1:0]      key_o,
  output logic                                  ge_o,
  output logic                                  eq_o
);

  logic signed [slt_pkg::KEY_W-1:0] key_r;
  logic                             ge_r;
  logic                             eq_r;

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      ge_r <= occupied && (key_r >= cmd.key);
      eq_r <= occupied && (key_r == cmd.key);
    end
    if (cmd.upd_ins) begin
      // open a slot: keys at or above the new one move right
      if (left_ge) begin
        key_r <= left_key;
      end else if (ge_r || at_end) begin
        key_r <= cmd.key;
      end
    end else if (cmd.upd_del && ge_r) begin
      // close the slot of the first match
      key_r <= right_key;
    end
  end

  assign key_o = key_r;
  assign ge_o  = ge_r;
  assign eq_o  = eq_r;

endmodule
`default_nettype wire

// ===== hdl/sorted_list_table.sv =====
// top level of the sorted list table: request control, cell chain, result register
//
//  channel | dir | transfer carries                  | handshake
//  --------+-----+-----------------------------------+------------------
//  in_req  | in  | req_type, key                     | valid / ready
//  out_rsp | out | found, status, entry_count        | valid / ready
//
// each request passes through three steps: accept, compare in every cell, shift update
// one request is in flight at a time; in_req.ready is high in the idle state
// a finished result waits in the output register while the next request is taken
// the update step stalls only when the output register is still full
// rst_n (synchronous, active low) empties the table; cell keys are not cleared
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_table #(
  parameter int unsigned CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  slt_req_if.sink   in_req,
  slt_rsp_if.source out_rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]  op_r;
  logic signed [slt_pkg::KEY_W-1:0] key_r;

  logic        out_valid_r;
  logic        out_found_r;
  logic [1:0]  out_status_r;
  logic [slt_pkg::COUNT_OUT_W-1:0] out_count_r;

  slt_pkg::cell_cmd_t cmd;

  logic signed [slt_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_eq;

  logic upd_fire;
  logic found;
  logic full;
  logic is_ins;
  logic is_del;
  logic [1:0] status;

  assign in_req.ready = (state_r == S_IDLE);

  // the output register must be free, or emptying this cycle
  assign upd_fire = (state_r == S_UPD) && (!out_valid_r || out_rsp.ready);

  // matching keys are contiguous, so any hit means present
  assign found  = |cell_eq;
  assign full   = (count_r == CW'(CAPACITY));
  assign is_ins = (op_r == slt_pkg::OP_INSERT);
  assign is_del = (op_r == slt_pkg::OP_DELETE);

  assign cmd.cmp_en  = (state_r == S_CMP);
  assign cmd.upd_ins = upd_fire && is_ins && !full;
  assign cmd.upd_del = upd_fire && is_del && found;
  assign cmd.key     = key_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.upd_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.upd_del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    if (is_ins) begin
      status = full ? slt_pkg::ST_FULL : slt_pkg::ST_OK;
    end else begin
      // search, delete and the unused code all report the lookup
      status = found ? slt_pkg::ST_OK : slt_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      op_r  <= in_req.req_type;
      key_r <= in_req.key;
    end
    if (upd_fire) begin
      out_found_r  <= found;
      out_status_r <= status;
      out_count_r  <= slt_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = out_count_r;

  // chain of cells, cell 0 holds the smallest key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [slt_pkg::KEY_W-1:0] lkey;
    logic signed [slt_pkg::KEY_W-1:0] rkey;
    logic lge;

    if (i == 0) begin : g_first
      assign lkey = '0;
      assign lge  = 1'b0;
    end else begin : g_mid
      assign lkey = cell_key[i-1];
      assign lge  = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // the last slot empties on a delete from a full table
      assign rkey = cell_key[i];
    end else begin : g_inner
      assign rkey = cell_key[i+1];
    end

    slt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (CW'(i) < count_r),
      .at_end    (CW'(i) == count_r),
      .left_key  (lkey),
      .left_ge   (lge),
      .right_key (rkey),
      .key_o     (cell_key[i]),
      .ge_o      (cell_ge[i]),
      .eq_o      (cell_eq[i])
    );
  end

endmodule
`default_nettype wire
